// File: hw/rtl/pes_pkg.sv
// shared types and codes for the periodic event scheduler
// no dependencies; used by pes_ctrl, pes_dp and periodic_event_scheduler
package pes_pkg;

    localparam int FIRE_TIME_W = 48;
    localparam int ID_W        = 16;
    localparam int PERIOD_W    = 16;
    localparam int STATUS_W    = 3;
    localparam int ACTION_W    = 2;

    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd1;

    localparam logic [STATUS_W-1:0] ST_FIRED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic do_clear;
        logic do_add;
        logic do_empty;
        logic scan_init;
        logic scan_step;
        logic writeback;
    } pes_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic act_clear;
        logic act_add;
        logic empty;
        logic scan_last;
    } pes_stat_t;

endpackage

// File: hw/rtl/pes_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module pes_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/pes_ctrl.sv
// sequencing state machine for the periodic event scheduler
// depends on pes_pkg; drives pes_dp through command and status structs
module pes_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  pes_pkg::pes_stat_t stat,
    output pes_pkg::pes_cmd_t  cmd,
    output logic              busy,
    output logic              done
);

    import pes_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_WB     = 3'd3;
    localparam logic [2:0] S_RESP   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.act_clear)
                begin
                    cmd.do_clear = 1'b1;
                    state_next   = S_RESP;
                end
                else if (stat.act_add)
                begin
                    cmd.do_add = 1'b1;
                    state_next = S_RESP;
                end
                else if (stat.empty)
                begin
                    cmd.do_empty = 1'b1;
                    state_next   = S_RESP;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                cmd.writeback = 1'b1;
                state_next    = S_RESP;
            end
            S_RESP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_RESP);

endmodule

// File: hw/rtl/pes_dp.sv
// datapath: task table ram, entry count, minimum search and result registers
// depends on pes_pkg and pes_ram; commanded by pes_ctrl
module pes_dp #(
    parameter int MAX_TASKS = 64,
    parameter int TIME_BITS = 48
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  pes_pkg::pes_cmd_t               cmd,
    output pes_pkg::pes_stat_t              stat,
    input  logic [pes_pkg::ACTION_W-1:0]    action,
    input  logic [pes_pkg::ID_W-1:0]        task_id,
    input  logic [pes_pkg::PERIOD_W-1:0]    period,
    output logic [pes_pkg::STATUS_W-1:0]    status,
    output logic [pes_pkg::ID_W-1:0]        fired_id,
    output logic [pes_pkg::FIRE_TIME_W-1:0] fire_time
);

    import pes_pkg::*;

    localparam int AW     = $clog2(MAX_TASKS);
    localparam int CW     = $clog2(MAX_TASKS + 1);
    localparam int WORD_W = ID_W + PERIOD_W + TIME_BITS;

    // latched request
    logic [ACTION_W-1:0] action_reg;
    logic [ID_W-1:0]     id_in_reg;
    logic [PERIOD_W-1:0] per_in_reg;

    logic [CW-1:0] count_reg;
    logic [AW-1:0] rd_idx_reg;
    logic [AW-1:0] pend_reg;
    logic          first_reg;

    logic [AW-1:0]        best_idx_reg;
    logic [ID_W-1:0]      best_id_reg;
    logic [PERIOD_W-1:0]  best_per_reg;
    logic [TIME_BITS-1:0] best_time_reg;

    logic [STATUS_W-1:0]    status_reg;
    logic [ID_W-1:0]        fired_id_reg;
    logic [FIRE_TIME_W-1:0] fire_time_reg;

    // ram ports
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    logic [ID_W-1:0]      rd_id;
    logic [PERIOD_W-1:0]  rd_per;
    logic [TIME_BITS-1:0] rd_time;
    logic                 take;
    logic                 full;
    logic [TIME_BITS:0]   adv_sum;
    logic [TIME_BITS-1:0] adv_time;
    logic [FIRE_TIME_W+TIME_BITS-1:0] best_time_ext;

    pes_ram #(
        .WIDTH(WORD_W),
        .DEPTH(MAX_TASKS)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign {rd_id, rd_per, rd_time} = ram_rdata;

    assign full = (count_reg == CW'(MAX_TASKS));

    // strict compare keeps the earlier entry on equal time and id
    assign take = first_reg || (rd_time < best_time_reg) ||
                  ((rd_time == best_time_reg) && (rd_id < best_id_reg));

    // saturating advance: carry out means the sum passed the largest time
    assign adv_sum  = {1'b0, best_time_reg} + (TIME_BITS + 1)'(best_per_reg);
    assign adv_time = adv_sum[TIME_BITS] ? '1 : adv_sum[TIME_BITS-1:0];

    assign best_time_ext = {{FIRE_TIME_W{1'b0}}, best_time_reg};

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = best_idx_reg;
        ram_wdata = {best_id_reg, best_per_reg, adv_time};
        if (cmd.do_add && !full)
        begin
            ram_we    = 1'b1;
            ram_waddr = count_reg[AW-1:0];
            ram_wdata = {id_in_reg, per_in_reg, TIME_BITS'(per_in_reg)};
        end
        else if (cmd.writeback)
        begin
            ram_we = 1'b1;
        end
    end

    assign ram_raddr = cmd.scan_init ? '0 : rd_idx_reg;

    assign stat.act_clear = (action_reg == ACT_CLEAR);
    assign stat.act_add   = (action_reg == ACT_ADD);
    assign stat.empty     = (count_reg == '0);
    assign stat.scan_last = (CW'(pend_reg) + CW'(1) == count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.do_clear)
        begin
            count_reg <= '0;
        end
        else if (cmd.do_add && !full)
        begin
            count_reg <= count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= action;
            id_in_reg  <= task_id;
            per_in_reg <= period;
        end

        if (cmd.scan_init)
        begin
            rd_idx_reg <= AW'(1);
            pend_reg   <= '0;
            first_reg  <= 1'b1;
        end
        else if (cmd.scan_step)
        begin
            rd_idx_reg <= rd_idx_reg + AW'(1);
            pend_reg   <= pend_reg + AW'(1);
            first_reg  <= 1'b0;
            if (take)
            begin
                best_idx_reg  <= pend_reg;
                best_id_reg   <= rd_id;
                best_per_reg  <= rd_per;
                best_time_reg <= rd_time;
            end
        end

        if (cmd.do_clear)
        begin
            status_reg    <= ST_CLEARED;
            fired_id_reg  <= '0;
            fire_time_reg <= '0;
        end
        else if (cmd.do_add)
        begin
            status_reg    <= full ? ST_FULL : ST_ADDED;
            fired_id_reg  <= '0;
            fire_time_reg <= '0;
        end
        else if (cmd.do_empty)
        begin
            status_reg    <= ST_EMPTY;
            fired_id_reg  <= '0;
            fire_time_reg <= '0;
        end
        else if (cmd.writeback)
        begin
            status_reg    <= ST_FIRED;
            fired_id_reg  <= best_id_reg;
            fire_time_reg <= best_time_ext[FIRE_TIME_W-1:0];
        end
    end

    assign status    = status_reg;
    assign fired_id  = fired_id_reg;
    assign fire_time = fire_time_reg;

endmodule

// File: hw/rtl/periodic_event_scheduler.sv
// top level of the periodic event scheduler
// depends on pes_pkg, pes_ctrl, pes_dp (which holds pes_ram)
//
//  channel   handshake            payload
//  request   start, busy          action, task_id, period
//  result    done (1-cycle pulse) status, fired_id, fire_time
//
// done rises after the decode state for clear, add and an empty table, and
// after the scan and write-back states for a next action (one ram read per entry,
// pipelined against the compare, then a write back of the advanced time);
// busy stays high through done, so a new request is taken only back in idle
// rst_n resets the entry count and the sequencer; table contents are kept.
// results cannot be held off: done lasts one cycle and busy stays high
// until it has been shown.
module periodic_event_scheduler #(
    parameter int MAX_TASKS = 64,
    parameter int TIME_BITS = 48
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [pes_pkg::ACTION_W-1:0]    action,
    input  logic [pes_pkg::ID_W-1:0]        task_id,
    input  logic [pes_pkg::PERIOD_W-1:0]    period,
    output logic                            done,
    output logic [pes_pkg::STATUS_W-1:0]    status,
    output logic [pes_pkg::ID_W-1:0]        fired_id,
    output logic [pes_pkg::FIRE_TIME_W-1:0] fire_time
);

    import pes_pkg::*;

    pes_cmd_t  cmd;
    pes_stat_t stat;

    pes_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .stat (stat),
        .cmd  (cmd),
        .busy (busy),
        .done (done)
    );

    pes_dp #(
        .MAX_TASKS(MAX_TASKS),
        .TIME_BITS(TIME_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .action   (action),
        .task_id  (task_id),
        .period   (period),
        .status   (status),
        .fired_id (fired_id),
        .fire_time(fire_time)
    );

endmodule
